// ----- rtl/ocean_spectrum_update_assert.svh -----
// Assertion macros used by the ocean spectrum update RTL (included by osu_disp).
`ifndef OCEAN_SPECTRUM_UPDATE_ASSERT_SVH
`define OCEAN_SPECTRUM_UPDATE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define OSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define OSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/osu_pkg.sv -----
// Types, constants and rounding helper for the ocean spectrum update.
package osu_pkg;

    localparam int DATA_W = 16;
    localparam int Q_FRAC = 14;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + 4;
    localparam int SH_W   = ACC_W - Q_FRAC;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (Q_FRAC - 1));
    localparam logic signed [SH_W-1:0]  SAT_MAX    = SH_W'(2 ** (DATA_W - 1) - 1);
    localparam logic signed [SH_W-1:0]  SAT_MIN    = SH_W'(-(2 ** (DATA_W - 1)));

    typedef logic signed [DATA_W-1:0] t_q14;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef struct packed {
        t_q14 h0_re;
        t_q14 h0_im;
        t_q14 h0c_re;
        t_q14 h0c_im;
        t_q14 dir_x;
        t_q14 dir_z;
        t_q14 cos_phase;
        t_q14 sin_phase;
        logic frame_end;
    } t_osu_in;

    typedef struct packed {
        t_q14 height_re;
        t_q14 height_im;
        t_q14 dispx_re;
        t_q14 dispx_im;
        t_q14 dispz_re;
        t_q14 dispz_im;
        logic frame_end_out;
    } t_osu_out;

    typedef struct packed {
        t_q14 hr;
        t_q14 hi;
        t_q14 dx;
        t_q14 dz;
        logic frame_end;
    } t_osu_height;

    // round half up (floor of v + half) then saturate to 16 bits
    function automatic t_q14 round_sat(input t_acc v);
        t_acc                  t;
        logic signed [SH_W-1:0] q;
        t = v + ROUND_HALF;
        q = t[ACC_W-1:Q_FRAC];
        if (q > SAT_MAX) begin
            q = SAT_MAX;
        end else if (q < SAT_MIN) begin
            q = SAT_MIN;
        end
        return q[DATA_W-1:0];
    endfunction

endpackage

// ----- rtl/ocean_spectrum_update.sv -----
// Top level of the ocean spectrum update: height and displacement pipeline.
//
//  channel | valid   | ready   | payload             | beat
//  --------+---------+---------+---------------------+---------------------------
//  input   | i_valid | o_ready | i_data (t_osu_in)   | one frequency bin
//  output  | o_valid | i_ready | o_data (t_osu_out)  | height and displacement bin
//
// Four register stages: height products, height sum/round, displacement
// products, displacement round into the output register.
// One bin per cycle sustained while i_ready stays high.
// Reset (i_rst_n low, synchronous) clears only the stage valid bits.
// Each stage holds its beat while the next one is full and stalled, so
// bubbles are squeezed out and nothing is dropped or repeated.
module ocean_spectrum_update (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  osu_pkg::t_osu_in  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output osu_pkg::t_osu_out o_data
);
    import osu_pkg::*;

    logic        h_valid;
    logic        h_ready;
    t_osu_height h_data;

    osu_height u_height (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (h_valid),
        .i_ready (h_ready),
        .o_data  (h_data)
    );

    osu_disp u_disp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (h_valid),
        .o_ready (h_ready),
        .i_data  (h_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

// ----- rtl/osu_height.sv -----
// Height spectrum: complex products, then sum, round and saturate.
module osu_height (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  osu_pkg::t_osu_in     i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output osu_pkg::t_osu_height o_data
);
    import osu_pkg::*;

    logic        r_vld1;
    logic        r_vld2;
    logic        rdy1;
    logic        rdy2;
    t_prod       r_p_ac, r_p_bs, r_p_pc, r_p_qs;
    t_prod       r_p_as, r_p_bc, r_p_qc, r_p_ps;
    t_q14        r_dx1, r_dz1;
    logic        r_fe1;
    t_acc        n_hr_acc, n_hi_acc;
    t_osu_height r_h;

    assign rdy2    = !r_vld2 || i_ready;
    assign rdy1    = !r_vld1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_vld2;
    assign o_data  = r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_vld1 <= i_valid;
            end
            if (rdy2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_p_ac <= i_data.h0_re  * i_data.cos_phase;
            r_p_bs <= i_data.h0_im  * i_data.sin_phase;
            r_p_pc <= i_data.h0c_re * i_data.cos_phase;
            r_p_qs <= i_data.h0c_im * i_data.sin_phase;
            r_p_as <= i_data.h0_re  * i_data.sin_phase;
            r_p_bc <= i_data.h0_im  * i_data.cos_phase;
            r_p_qc <= i_data.h0c_im * i_data.cos_phase;
            r_p_ps <= i_data.h0c_re * i_data.sin_phase;
            r_dx1  <= i_data.dir_x;
            r_dz1  <= i_data.dir_z;
            r_fe1  <= i_data.frame_end;
        end
    end

    always_comb begin
        n_hr_acc = ACC_W'(r_p_ac) - ACC_W'(r_p_bs) + ACC_W'(r_p_pc) + ACC_W'(r_p_qs);
        n_hi_acc = ACC_W'(r_p_as) + ACC_W'(r_p_bc) + ACC_W'(r_p_qc) - ACC_W'(r_p_ps);
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_vld1) begin
            r_h.hr        <= round_sat(n_hr_acc);
            r_h.hi        <= round_sat(n_hi_acc);
            r_h.dx        <= r_dx1;
            r_h.dz        <= r_dz1;
            r_h.frame_end <= r_fe1;
        end
    end

endmodule

// ----- rtl/osu_disp.sv -----
// Displacement spectra from the rounded height, plus the output register.
`include "ocean_spectrum_update_assert.svh"

module osu_disp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  osu_pkg::t_osu_height i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output osu_pkg::t_osu_out    o_data
);
    import osu_pkg::*;

    logic     r_vld3;
    logic     r_vld4;
    logic     rdy3;
    logic     rdy4;
    t_prod    r_p_xi, r_p_xr, r_p_zi, r_p_zr;
    t_q14     r_hr3, r_hi3;
    logic     r_fe3;
    t_osu_out r_out;

    assign rdy4    = !r_vld4 || i_ready;
    assign rdy3    = !r_vld3 || rdy4;
    assign o_ready = rdy3;
    assign o_valid = r_vld4;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (rdy3) begin
                r_vld3 <= i_valid;
            end
            if (rdy4) begin
                r_vld4 <= r_vld3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && i_valid) begin
            r_p_xi <= i_data.dx * i_data.hi;
            r_p_xr <= i_data.dx * i_data.hr;
            r_p_zi <= i_data.dz * i_data.hi;
            r_p_zr <= i_data.dz * i_data.hr;
            r_hr3  <= i_data.hr;
            r_hi3  <= i_data.hi;
            r_fe3  <= i_data.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_vld3) begin
            r_out.height_re     <= r_hr3;
            r_out.height_im     <= r_hi3;
            r_out.dispx_re      <= round_sat(ACC_W'(r_p_xi));
            r_out.dispx_im      <= round_sat(-ACC_W'(r_p_xr));
            r_out.dispz_re      <= round_sat(ACC_W'(r_p_zi));
            r_out.dispz_im      <= round_sat(-ACC_W'(r_p_zr));
            r_out.frame_end_out <= r_fe3;
        end
    end

    `OSU_ASSERT_NEXT(a_stall_keeps_item, i_clk, i_rst_n, r_vld3 && !rdy4, r_vld3,
        "stalled displacement stage lost its beat")
    `OSU_ASSERT_NOW(a_empty_out_accepts, i_clk, i_rst_n, !r_vld4, o_ready,
        "upstream blocked while output register is empty")
    `OSU_ASSERT_NOW(a_out_from_stage3, i_clk, i_rst_n, $rose(r_vld4), $past(r_vld3),
        "output beat appeared without a product stage beat")

endmodule

// ----- tb/ocean_spectrum_update_chk.sv -----
`timescale 1ns / 1ps
// Checker for the ocean spectrum update: predicts each bin's spectra and compares output beats.
module ocean_spectrum_update_chk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  osu_pkg::t_osu_in  i_in_bin,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  osu_pkg::t_osu_out i_out_bin,
    output int                o_fail_count,
    output int                o_checked,
    output int                o_rail_hits,
    output int                o_pending
);
    import osu_pkg::*;

    localparam int MAX_PRINTED = 40;

    t_osu_out spectra_q[$];

    // round half up to Q1.14, then clamp to 16 bits
    function automatic t_q14 q14_fix(input longint acc);
        longint r;
        r = (acc + 64'sd8192) >>> Q_FRAC;
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return t_q14'(r);
    endfunction

    function automatic t_osu_out spectrum_of(input t_osu_in src);
        longint   a, b, p, q, dx, dz, c, s;
        t_osu_out r;
        a  = src.h0_re;
        b  = src.h0_im;
        p  = src.h0c_re;
        q  = src.h0c_im;
        dx = src.dir_x;
        dz = src.dir_z;
        c  = src.cos_phase;
        s  = src.sin_phase;
        r.height_re     = q14_fix(a * c - b * s + p * c + q * s);
        r.height_im     = q14_fix(a * s + b * c + q * c - p * s);
        // displacements work from the clamped 16-bit height
        r.dispx_re      = q14_fix(dx * longint'(r.height_im));
        r.dispx_im      = q14_fix(-(dx * longint'(r.height_re)));
        r.dispz_re      = q14_fix(dz * longint'(r.height_im));
        r.dispz_im      = q14_fix(-(dz * longint'(r.height_re)));
        r.frame_end_out = src.frame_end;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        o_fail_count++;
        if (o_fail_count <= MAX_PRINTED) begin
            $display("%0t: result %0d, %s: got %0d, expected %0d",
                     $time, o_checked, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        t_osu_out want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                spectra_q = {spectra_q, spectrum_of(i_in_bin)};
            end
            if (i_out_valid && i_out_ready) begin
                if (spectra_q.size() == 0) begin
                    report_mismatch("output beat with nothing pending", 1, 0);
                end else begin
                    want = spectra_q.pop_front();
                    if (i_out_bin.height_re != want.height_re) begin
                        report_mismatch("height_re", i_out_bin.height_re, want.height_re);
                    end
                    if (i_out_bin.height_im != want.height_im) begin
                        report_mismatch("height_im", i_out_bin.height_im, want.height_im);
                    end
                    if (i_out_bin.dispx_re != want.dispx_re) begin
                        report_mismatch("dispx_re", i_out_bin.dispx_re, want.dispx_re);
                    end
                    if (i_out_bin.dispx_im != want.dispx_im) begin
                        report_mismatch("dispx_im", i_out_bin.dispx_im, want.dispx_im);
                    end
                    if (i_out_bin.dispz_re != want.dispz_re) begin
                        report_mismatch("dispz_re", i_out_bin.dispz_re, want.dispz_re);
                    end
                    if (i_out_bin.dispz_im != want.dispz_im) begin
                        report_mismatch("dispz_im", i_out_bin.dispz_im, want.dispz_im);
                    end
                    if (i_out_bin.frame_end_out !== want.frame_end_out) begin
                        report_mismatch("frame_end_out", i_out_bin.frame_end_out,
                                        want.frame_end_out);
                    end
                    if (want.height_re == 16'sh7fff || want.height_re == -16'sh8000 ||
                        want.height_im == 16'sh7fff || want.height_im == -16'sh8000) begin
                        o_rail_hits++;
                    end
                    o_checked++;
                end
            end
            o_pending <= spectra_q.size();
        end
    end

endmodule

// ----- tb/ocean_spectrum_update_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the ocean spectrum update: stimulus, sink stalls, watchdog and verdict.
module ocean_spectrum_update_tb;
    import osu_pkg::*;

    localparam int N_RANDOM       = 1580;
    localparam int STALL_PCT      = 18;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;

    logic     i_clk    = 1'b0;
    logic     i_rst_n  = 1'b0;
    logic     i_valid  = 1'b0;
    logic     o_ready;
    t_osu_in  i_data   = '0;
    logic     o_valid;
    logic     i_ready  = 1'b0;
    t_osu_out o_data;
    logic     stall_en = 1'b1;

    int bins_sent;
    int n_directed;
    int frame_ends_sent;
    int quiet_cycles;
    int fail_count;
    int checked;
    int rail_hits;
    int pending;

    always #5 i_clk = ~i_clk;

    ocean_spectrum_update i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    ocean_spectrum_update_chk i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_bin     (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_bin    (o_data),
        .o_fail_count (fail_count),
        .o_checked    (checked),
        .o_rail_hits  (rail_hits),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        i_ready <= stall_en ? ($urandom_range(99) >= STALL_PCT) : 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, pending);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_osu_in make_bin(input int a, input int b, input int p, input int q,
                                         input int dx, input int dz, input int c, input int s,
                                         input bit fe);
        t_osu_in r;
        r.h0_re     = t_q14'(a);
        r.h0_im     = t_q14'(b);
        r.h0c_re    = t_q14'(p);
        r.h0c_im    = t_q14'(q);
        r.dir_x     = t_q14'(dx);
        r.dir_z     = t_q14'(dz);
        r.cos_phase = t_q14'(c);
        r.sin_phase = t_q14'(s);
        r.frame_end = fe;
        return r;
    endfunction

    function automatic t_q14 unit_range();
        return t_q14'(int'($urandom_range(32768)) - 16384);
    endfunction

    function automatic t_q14 edge_value();
        case ($urandom_range(6))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return 16'sh4000;
            3: return -16'sh4000;
            4: return 16'sh0001;
            5: return -16'sh0001;
            default: return '0;
        endcase
    endfunction

    function automatic t_osu_in rand_bin();
        t_osu_in r;
        int      mode;
        mode = $urandom_range(99);
        r = {$urandom(), $urandom(), $urandom(), $urandom(), 1'b0};
        if (mode < 70) begin
            // physically plausible bin; amplitudes sometimes left full range
            if ($urandom_range(3) != 0) begin
                r.h0_re  = unit_range();
                r.h0_im  = unit_range();
                r.h0c_re = unit_range();
                r.h0c_im = unit_range();
            end
            r.dir_x     = unit_range();
            r.dir_z     = unit_range();
            r.cos_phase = unit_range();
            r.sin_phase = unit_range();
            r.frame_end = ($urandom_range(63) == 0);
        end else if (mode < 85) begin
            r.frame_end = 1'($urandom_range(1));
        end else begin
            r.h0_re     = edge_value();
            r.h0_im     = edge_value();
            r.h0c_re    = edge_value();
            r.h0c_im    = edge_value();
            r.dir_x     = edge_value();
            r.dir_z     = edge_value();
            r.cos_phase = edge_value();
            r.sin_phase = edge_value();
            r.frame_end = 1'($urandom_range(1));
        end
        return r;
    endfunction

    task automatic send_bin(input t_osu_in b);
        while (stall_en && $urandom_range(99) < STALL_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        do @(posedge i_clk); while (!o_ready);
        bins_sent++;
        if (b.frame_end) begin
            frame_ends_sent++;
        end
    endtask

    initial begin
        t_osu_in directed[$];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed = {directed, make_bin(0, 0, 0, 0, 0, 0, 0, 0, 1'b0)};
        directed = {directed, make_bin(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                       32767, 1'b1)};
        directed = {directed, make_bin(-32768, -32768, -32768, -32768, -32768, -32768,
                                       -32768, -32768, 1'b0)};
        directed = {directed, make_bin(16384, 0, 0, 0, 16384, 0, 16384, 0, 1'b0)};
        directed = {directed, make_bin(0, 16384, 16384, 0, 0, 16384, 0, 16384, 1'b0)};
        directed = {directed, make_bin(5000, -3000, 1200, 700, -16384, -16384, -16384,
                                       -16384, 1'b1)};
        // rounding ties and just below a tie
        directed = {directed, make_bin(1, 0, 0, 0, 16384, 16384, 8192, 0, 1'b0)};
        directed = {directed, make_bin(-1, 0, 0, 0, 16384, 16384, 8192, 0, 1'b0)};
        directed = {directed, make_bin(-3, 0, 0, 0, 16384, 16384, 8192, 0, 1'b0)};
        directed = {directed, make_bin(1, 0, 0, 0, 16384, 16384, 8191, 0, 1'b0)};
        directed = {directed, make_bin(0, 1, 0, 0, 0, 0, 0, 8192, 1'b0)};
        // height saturation both ways
        directed = {directed, make_bin(32767, 0, 32767, 0, 0, 0, 16384, 0, 1'b0)};
        directed = {directed, make_bin(-32768, 0, -32768, 0, 0, 0, 16384, 0, 1'b0)};
        directed = {directed, make_bin(0, 32767, 0, -32768, 0, 0, 0, 16384, 1'b0)};
        // displacement saturation from out-of-range direction
        directed = {directed, make_bin(-32768, -32768, -32768, -32768, -32768, 32767, 16384,
                                       0, 1'b1)};
        directed = {directed, make_bin(32767, 32767, 32767, 32767, 32767, -32768, 16384, 0,
                                       1'b0)};
        // out-of-range phase terms
        directed = {directed, make_bin(8000, -6000, 4000, 2000, 11585, -11585, -32768, 32767,
                                       1'b0)};
        directed = {directed, make_bin(-12000, 9000, 300, -4500, -11585, 11585, 32767, -32768,
                                       1'b0)};
        // conjugate pair gives a purely real height
        directed = {directed, make_bin(7000, 3000, 7000, -3000, 11585, 11585, 11585, 11585,
                                       1'b0)};
        directed = {directed, make_bin(-1, -1, -1, -1, -1, -1, -1, -1, 1'b1)};
        n_directed = directed.size();
        foreach (directed[k]) begin
            send_bin(directed[k]);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == 500) begin
                stall_en <= 1'b0;
            end else if (k == 900) begin
                stall_en <= 1'b1;
            end
            send_bin(rand_bin());
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("streamed %0d bins (%0d directed, %0d with frame end) under random stalls",
                 bins_sent, n_directed, frame_ends_sent);
        $display("compared %0d result beats, %0d with a height component at a rail",
                 checked, rail_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/osu_pkg.sv
rtl/osu_height.sv
rtl/osu_disp.sv
rtl/ocean_spectrum_update.sv
tb/ocean_spectrum_update_chk.sv
tb/ocean_spectrum_update_tb.sv
